// File: rtl/bpu_pkg.sv
`default_nettype none

package bpu_pkg;

   // Field widths
   localparam int PIXEL_W    = 32;
   localparam int PIXEL16_W  = 16;
   localparam int CHAN_W     = 8;
   localparam int KEY_W      = 24;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Scaling datapath: numerator is field * 255, one quotient bit per stage
   localparam int REM_W    = PIXEL_W + CHAN_W;
   localparam int DIV_STG  = CHAN_W;
   localparam int LANE_STG = DIV_STG + 1;
   localparam int NUM_STG  = LANE_STG + 1;

   // Channel lanes
   localparam int NUM_CHAN = 4;
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_ALPHA = 3;

   // Pixel modes (mode 3 decodes like 32-bit masked)
   localparam logic [MODE_W-1:0] MODE_16 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_24 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

   // Fixed byte masks for 24-bit BGR pixels
   localparam logic [PIXEL_W-1:0] BGR_RED_MASK   = 32'h00FF_0000;
   localparam logic [PIXEL_W-1:0] BGR_GREEN_MASK = 32'h0000_FF00;
   localparam logic [PIXEL_W-1:0] BGR_BLUE_MASK  = 32'h0000_00FF;

   // Register reset values
   localparam logic [MODE_W-1:0]  RST_PIXEL_MODE = MODE_32;
   localparam logic [PIXEL_W-1:0] RST_RED_MASK   = 32'h00FF_0000;
   localparam logic [PIXEL_W-1:0] RST_GREEN_MASK = 32'h0000_FF00;
   localparam logic [PIXEL_W-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
   localparam logic [PIXEL_W-1:0] RST_ALPHA_MASK = 32'h0000_0000;
   localparam logic [KEY_W-1:0]   RST_KEY_COLOR  = 24'h00_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_MODE   = 3'd0,
      CSR_RED_MASK     = 3'd1,
      CSR_GREEN_MASK   = 3'd2,
      CSR_BLUE_MASK    = 3'd3,
      CSR_ALPHA_MASK   = 3'd4,
      CSR_ALPHA_ENABLE = 3'd5,
      CSR_KEY_ENABLE   = 3'd6,
      CSR_KEY_COLOR    = 3'd7
   } csr_idx_type;

   // Per-stage load strobes for a scaling lane
   typedef struct packed {
      logic [LANE_STG-1:0] load;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/bpu_req_if.sv
`default_nettype none

interface bpu_req_if;
   import bpu_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

`default_nettype wire

// File: rtl/bpu_rsp_if.sv
`default_nettype none

interface bpu_rsp_if;
   import bpu_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;
   logic              transparent;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output transparent, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input transparent, output ready);
endinterface

`default_nettype wire

// File: rtl/bpu_scale_lane.sv
`default_nettype none

// One channel: floor((word & mask) * 255 / mask), one quotient bit per stage.
// Shifting both field and mask down to the mask's lowest set bit leaves the
// quotient unchanged, so no shift is needed. The mask must be held static while
// items are in flight (the block does not enforce this), so every stage reads it directly.
module bpu_scale_lane (
   input  wire                          clock,
   input  bpu_pkg::lane_ctrl_type       ctrl,
   input  wire [bpu_pkg::PIXEL_W-1:0]   word,
   input  wire [bpu_pkg::PIXEL_W-1:0]   mask,
   output logic [bpu_pkg::CHAN_W-1:0]  quot
);
   import bpu_pkg::*;

   logic [REM_W-1:0]  field_ext;
   logic [REM_W-1:0]  rem_in [0:DIV_STG-1];
   logic [REM_W-1:0]  rem_ff [0:DIV_STG-1];
   logic [CHAN_W-1:0] quo_in [1:DIV_STG];
   logic [CHAN_W-1:0] quo_ff [1:DIV_STG];

   // Form the numerator: field * 255 as (field << 8) - field
   assign field_ext = REM_W'(word & mask);
   assign rem_in[0] = (field_ext << CHAN_W) - field_ext;

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         rem_ff[0] <= rem_in[0];
      end
   end

   // Restoring division, most significant quotient bit first
   for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
      localparam int BIT_POS = DIV_STG - k;
      logic [REM_W-1:0] dsh;
      logic             take;

      assign dsh  = REM_W'(mask) << BIT_POS;
      assign take = (rem_ff[k-1] >= dsh);

      if (k == 1) begin : g_first
         assign quo_in[k] = CHAN_W'(take);
      end else begin : g_next
         assign quo_in[k] = {quo_ff[k-1][CHAN_W-2:0], take};
      end

      if (k < DIV_STG) begin : g_rem
         assign rem_in[k] = take ? (rem_ff[k-1] - dsh) : rem_ff[k-1];
         always_ff @(posedge clock) begin
            if (ctrl.load[k]) begin
               rem_ff[k] <= rem_in[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.load[k]) begin
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quot = quo_ff[DIV_STG];

endmodule

`default_nettype wire

// File: rtl/bitfield_pixel_unpacker_unit.sv
`default_nettype none

// Bitfield pixel unpacker. Each item is one raw pixel word; each result is
// 8-bit red, green, blue, alpha and a colour-key transparency flag. Items are
// taken one per clock unless the pipe is full and stalled on the result side.
// Each passes one stage that forms field * 255 per channel, eight stages that
// run a restoring division against the channel mask at one quotient bit each,
// and a final register that captures the result with the key compare made on
// the division outputs. A stall on the result side freezes only full stages,
// so empty stages keep filling. Registers are written through the csr_ port
// and must only change while no item is in flight; 24-bit mode reuses the
// masked datapath with fixed byte masks and forces alpha to zero.
module bitfield_pixel_unpacker_unit (
   input  wire                             clock,
   input  wire                             reset,
   bpu_req_if.sink                         req_ch,
   bpu_rsp_if.source                       rsp_ch,
   input  wire                             csr_we,
   input  wire [bpu_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire [bpu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bpu_pkg::*;

   // Configuration registers
   logic [MODE_W-1:0]  pixel_mode_ff;
   logic [PIXEL_W-1:0] red_mask_ff;
   logic [PIXEL_W-1:0] green_mask_ff;
   logic [PIXEL_W-1:0] blue_mask_ff;
   logic [PIXEL_W-1:0] alpha_mask_ff;
   logic               alpha_enable_ff;
   logic               key_enable_ff;
   logic [KEY_W-1:0]   key_color_ff;

   // Pipeline control
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG-1:0] rdy;
   logic [NUM_STG-1:0] load;
   lane_ctrl_type      lane_ctrl;

   // Datapath
   logic [PIXEL_W-1:0] word_eff;
   logic [PIXEL_W-1:0] mask_eff [0:NUM_CHAN-1];
   logic [CHAN_W-1:0]  quot     [0:NUM_CHAN-1];
   logic [CHAN_W-1:0]  chan_in  [0:NUM_CHAN-1];
   logic               trans_in;

   // Output register
   logic [CHAN_W-1:0]  red_ff;
   logic [CHAN_W-1:0]  green_ff;
   logic [CHAN_W-1:0]  blue_ff;
   logic [CHAN_W-1:0]  alpha_ff;
   logic               trans_ff;

   // Write configuration registers; every index names a register
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff   <= RST_PIXEL_MODE;
         red_mask_ff     <= RST_RED_MASK;
         green_mask_ff   <= RST_GREEN_MASK;
         blue_mask_ff    <= RST_BLUE_MASK;
         alpha_mask_ff   <= RST_ALPHA_MASK;
         alpha_enable_ff <= 1'b0;
         key_enable_ff   <= 1'b0;
         key_color_ff    <= RST_KEY_COLOR;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_PIXEL_MODE:   pixel_mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_RED_MASK:     red_mask_ff     <= csr_wdata[PIXEL_W-1:0];
            CSR_GREEN_MASK:   green_mask_ff   <= csr_wdata[PIXEL_W-1:0];
            CSR_BLUE_MASK:    blue_mask_ff    <= csr_wdata[PIXEL_W-1:0];
            CSR_ALPHA_MASK:   alpha_mask_ff   <= csr_wdata[PIXEL_W-1:0];
            CSR_ALPHA_ENABLE: alpha_enable_ff <= csr_wdata[0];
            CSR_KEY_ENABLE:   key_enable_ff   <= csr_wdata[0];
            CSR_KEY_COLOR:    key_color_ff    <= csr_wdata[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Select the masks each lane divides by for the current mode
   always_comb begin
      if (pixel_mode_ff == MODE_24) begin
         mask_eff[CH_RED]   = BGR_RED_MASK;
         mask_eff[CH_GREEN] = BGR_GREEN_MASK;
         mask_eff[CH_BLUE]  = BGR_BLUE_MASK;
         mask_eff[CH_ALPHA] = '0;
      end else begin
         mask_eff[CH_RED]   = red_mask_ff;
         mask_eff[CH_GREEN] = green_mask_ff;
         mask_eff[CH_BLUE]  = blue_mask_ff;
         mask_eff[CH_ALPHA] = alpha_enable_ff ? alpha_mask_ff : '0;
      end
   end

   // Drop the upper half of the word in 16-bit mode
   assign word_eff = (pixel_mode_ff == MODE_16) ?
                     PIXEL_W'(req_ch.pixel_word[PIXEL16_W-1:0]) : req_ch.pixel_word;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      rdy[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_ch.ready;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      load[0]   = rdy[0] && req_ch.valid;
      vld_in[0] = rdy[0] ? req_ch.valid : vld_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         load[k]   = rdy[k] && vld_ff[k-1];
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign lane_ctrl.load = load[LANE_STG-1:0];
   assign req_ch.ready   = rdy[0];

   // Scale each channel in its own lane
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
      bpu_scale_lane u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .word  (word_eff),
         .mask  (mask_eff[c]),
         .quot  (quot[c])
      );
      // A zero mask gives zero instead of a division result
      assign chan_in[c] = (mask_eff[c] == '0) ? '0 : quot[c];
   end

   // Match the colour key on the final values
   assign trans_in = key_enable_ff && (chan_in[CH_ALPHA] == '0) &&
                     ({chan_in[CH_RED], chan_in[CH_GREEN], chan_in[CH_BLUE]} == key_color_ff);

   always_ff @(posedge clock) begin
      if (load[NUM_STG-1]) begin
         red_ff   <= chan_in[CH_RED];
         green_ff <= chan_in[CH_GREEN];
         blue_ff  <= chan_in[CH_BLUE];
         alpha_ff <= chan_in[CH_ALPHA];
         trans_ff <= trans_in;
      end
   end

   assign rsp_ch.valid       = vld_ff[NUM_STG-1];
   assign rsp_ch.red         = red_ff;
   assign rsp_ch.green       = green_ff;
   assign rsp_ch.blue        = blue_ff;
   assign rsp_ch.alpha       = alpha_ff;
   assign rsp_ch.transparent = trans_ff;

`ifndef SYNTHESIS
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[0])
      else $error("accepted item did not enter the first stage");

   a_bgr_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && pixel_mode_ff == MODE_24) |-> (rsp_ch.alpha == '0))
      else $error("alpha nonzero in 24-bit mode");

   a_trans_needs_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.transparent) |-> (key_enable_ff && rsp_ch.alpha == '0))
      else $error("transparent flag without key enable or with alpha");

   a_zero_red_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && pixel_mode_ff != MODE_24 && red_mask_ff == '0)
      |-> (rsp_ch.red == '0))
      else $error("zero red mask gave nonzero red");
`endif

endmodule

`default_nettype wire

// File: sim/bitfield_pixel_unpacker_unit_tb.sv
`timescale 1ns / 100ps

module bitfield_pixel_unpacker_unit_tb;
   import bpu_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int LONG_STALL      = 300;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int NUM_RAND_PHASES = 22;
   localparam int REPORT_MAX      = 10;

   // Mode 3 has no package name; it decodes like 32-bit masked
   localparam logic [MODE_W-1:0] MODE_32_ALIAS = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              transparent;
   } decoded_pixel_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bpu_req_if req_if ();
   bpu_rsp_if rsp_if ();

   bitfield_pixel_unpacker_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the unit's registers
   logic [MODE_W-1:0]  mode_cfg     = RST_PIXEL_MODE;
   logic [PIXEL_W-1:0] red_mask_cfg = RST_RED_MASK;
   logic [PIXEL_W-1:0] grn_mask_cfg = RST_GREEN_MASK;
   logic [PIXEL_W-1:0] blu_mask_cfg = RST_BLUE_MASK;
   logic [PIXEL_W-1:0] alp_mask_cfg = RST_ALPHA_MASK;
   logic               alpha_en_cfg = 1'b0;
   logic               key_en_cfg   = 1'b0;
   logic [KEY_W-1:0]   key_cfg      = RST_KEY_COLOR;

   logic [PIXEL_W-1:0] pixel_q[$];
   decoded_pixel_type  decoded_q[$];

   int src_idle_pct  = 0;
   int snk_stall_pct = 0;
   int stall_req_cnt = 0;
   int accepted_cnt  = 0;
   int checked_cnt   = 0;
   int keyed_cnt     = 0;
   int err_cnt       = 0;
   int setting_cnt   = 0;
   int cycle_cnt     = 0;
   logic req_fire    = 1'b0;

   decoded_pixel_type got_px;
   decoded_pixel_type want_px;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Scale one masked field to 8 bits; a zero mask gives 0
   function automatic logic [CHAN_W-1:0] field_to_byte(logic [PIXEL_W-1:0] word,
                                                       logic [PIXEL_W-1:0] mask);
      int unsigned        sh;
      logic [PIXEL_W-1:0] raw;
      logic [PIXEL_W-1:0] span;
      logic [63:0]        quot;
      if (mask == '0) return '0;
      sh = 0;
      while (sh < 31 && mask[sh] == 1'b0) sh++;
      raw  = (word & mask) >> sh;
      span = mask >> sh;
      quot = ({32'd0, raw} * 64'd255) / {32'd0, span};
      return quot[CHAN_W-1:0];
   endfunction

   function automatic decoded_pixel_type decode_pixel(logic [PIXEL_W-1:0] word);
      decoded_pixel_type px;
      px = '0;
      if (mode_cfg == MODE_24) begin
         px.blue  = word[7:0];
         px.green = word[15:8];
         px.red   = word[23:16];
      end else begin
         if (mode_cfg == MODE_16) word = {16'd0, word[PIXEL16_W-1:0]};
         px.red   = field_to_byte(word, red_mask_cfg);
         px.green = field_to_byte(word, grn_mask_cfg);
         px.blue  = field_to_byte(word, blu_mask_cfg);
         if (alpha_en_cfg && alp_mask_cfg != '0) px.alpha = field_to_byte(word, alp_mask_cfg);
      end
      px.transparent = key_en_cfg && ({px.red, px.green, px.blue} == key_cfg) &&
                       (px.alpha == '0);
      return px;
   endfunction

   // Mostly contiguous fields of random width and position, some edge masks
   function automatic logic [PIXEL_W-1:0] rand_mask();
      int unsigned w;
      int unsigned pos;
      logic [63:0] ones;
      w = $urandom_range(32, 1);
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         5: return $urandom;
         6: begin
            w   = $urandom_range(16, 1);
            pos = $urandom_range(16 - w, 0);
         end
         7: begin
            w   = 1;
            pos = $urandom_range(31, 0);
         end
         default: pos = $urandom_range(32 - w, 0);
      endcase
      ones = (64'd1 << w) - 64'd1;
      return ones[31:0] << pos;
   endfunction

   // Bias toward the key word so the colour key is hit now and then
   function automatic logic [PIXEL_W-1:0] rand_pixel(logic [PIXEL_W-1:0] key_word);
      logic [PIXEL_W-1:0] noise;
      noise = $urandom;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return key_word;
         4: return key_word ^ {noise[7:0], 24'd0};
         default: return noise;
      endcase
   endfunction

   // Write one register and mirror it into the shadow copy
   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PIXEL_MODE:   mode_cfg     = val[MODE_W-1:0];
         CSR_RED_MASK:     red_mask_cfg = val;
         CSR_GREEN_MASK:   grn_mask_cfg = val;
         CSR_BLUE_MASK:    blu_mask_cfg = val;
         CSR_ALPHA_MASK:   alp_mask_cfg = val;
         CSR_ALPHA_ENABLE: alpha_en_cfg = val[0];
         CSR_KEY_ENABLE:   key_en_cfg   = val[0];
         CSR_KEY_COLOR:    key_cfg      = val[KEY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued pixel is decoded, then let the pipe settle
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (pixel_q.size() != 0 || decoded_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pixel driver: hold an offered item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            req_if.valid      <= 1'b1;
            req_if.pixel_word <= pixel_q[0];
         end else begin
            req_if.valid      <= 1'b0;
            req_if.pixel_word <= $urandom;
         end
      end
   end

   // Result sink: random stalls, plus a long hold-off on request
   always @(negedge clock) begin : sink_proc
      int stall_ack_cnt;
      int stall_left;
      if (stall_ack_cnt != stall_req_cnt) begin
         stall_ack_cnt = stall_req_cnt;
         stall_left    = LONG_STALL;
      end
      if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Predict on accepted pixels, check each result against the oldest prediction
   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         want_px = decode_pixel(req_if.pixel_word);
         if (want_px.transparent) keyed_cnt++;
         decoded_q.push_back(want_px);
         void'(pixel_q.pop_front());
         accepted_cnt++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_px = '{red: rsp_if.red, green: rsp_if.green, blue: rsp_if.blue,
                    alpha: rsp_if.alpha, transparent: rsp_if.transparent};
         if (decoded_q.size() == 0) begin
            if (err_cnt < REPORT_MAX)
               $display("ERROR: result with no pixel pending: r=%02h g=%02h b=%02h a=%02h t=%0b",
                        got_px.red, got_px.green, got_px.blue, got_px.alpha,
                        got_px.transparent);
            err_cnt++;
         end else begin
            want_px = decoded_q.pop_front();
            if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
                got_px.blue !== want_px.blue || got_px.alpha !== want_px.alpha ||
                got_px.transparent !== want_px.transparent) begin
               if (err_cnt < REPORT_MAX)
                  $display("ERROR: result %0d: exp %02h %02h %02h %02h %0b got %02h %02h %02h %02h %0b",
                           checked_cnt,
                           want_px.red, want_px.green, want_px.blue, want_px.alpha,
                           want_px.transparent, got_px.red, got_px.green, got_px.blue,
                           got_px.alpha, got_px.transparent);
               err_cnt++;
            end
            checked_cnt++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
                  decoded_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [PIXEL_W-1:0] masks[4];
      logic [PIXEL_W-1:0] key_word;
      decoded_pixel_type  key_px;
      int                 k;

      req_if.valid      = 1'b0;
      req_if.pixel_word = '0;
      rsp_if.ready      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: 32-bit with byte-wide masks
      @(posedge clock);
      pixel_q.push_back(32'h0000_0000);
      pixel_q.push_back(32'hFFFF_FFFF);
      pixel_q.push_back(32'h00FF_00FF);
      pixel_q.push_back(32'h1234_5678);
      wait_drained();
      setting_cnt++;

      // 24-bit BGR: alpha forced to zero even when enabled, key match
      write_reg(CSR_PIXEL_MODE, 32'(MODE_24));
      write_reg(CSR_ALPHA_MASK, 32'hFF00_0000);
      write_reg(CSR_ALPHA_ENABLE, 32'd1);
      write_reg(CSR_KEY_ENABLE, 32'd1);
      write_reg(CSR_KEY_COLOR, 32'h0012_3456);
      @(posedge clock);
      pixel_q.push_back(32'h0012_3456);
      pixel_q.push_back(32'hFF12_3456);
      pixel_q.push_back(32'hFFFF_FFFF);
      wait_drained();
      setting_cnt++;

      // 16-bit 565, zero alpha mask disables alpha, key on black
      write_reg(CSR_PIXEL_MODE, 32'(MODE_16));
      write_reg(CSR_RED_MASK, 32'h0000_F800);
      write_reg(CSR_GREEN_MASK, 32'h0000_07E0);
      write_reg(CSR_BLUE_MASK, 32'h0000_001F);
      write_reg(CSR_ALPHA_MASK, 32'h0000_0000);
      write_reg(CSR_KEY_COLOR, 32'h0000_0000);
      @(posedge clock);
      pixel_q.push_back(32'h0000_FFFF);
      pixel_q.push_back(32'h0000_0000);
      pixel_q.push_back(32'h0000_F800);
      pixel_q.push_back(32'hFFFF_0000);
      wait_drained();
      setting_cnt++;

      // 16-bit with a mask bit above the pixel and a zero green mask
      write_reg(CSR_RED_MASK, 32'h0001_F800);
      write_reg(CSR_GREEN_MASK, 32'h0000_0000);
      @(posedge clock);
      pixel_q.push_back(32'h0000_FFFF);
      pixel_q.push_back(32'h0001_F800);
      pixel_q.push_back(32'h0000_07FF);
      wait_drained();
      setting_cnt++;

      // Mode 3 with a top single-bit mask, a full-word mask and an alpha byte
      write_reg(CSR_PIXEL_MODE, 32'(MODE_32_ALIAS));
      write_reg(CSR_RED_MASK, 32'h8000_0000);
      write_reg(CSR_GREEN_MASK, 32'hFFFF_FFFF);
      write_reg(CSR_BLUE_MASK, 32'h0000_0001);
      write_reg(CSR_ALPHA_MASK, 32'hFF00_0000);
      @(posedge clock);
      pixel_q.push_back(32'hFFFF_FFFF);
      pixel_q.push_back(32'h7FFF_FFFE);
      pixel_q.push_back(32'h8000_0001);
      wait_drained();
      setting_cnt++;

      // 32-bit ARGB, white key: nonzero alpha blocks the match until alpha is disabled
      write_reg(CSR_PIXEL_MODE, 32'(MODE_32));
      write_reg(CSR_RED_MASK, 32'h00FF_0000);
      write_reg(CSR_GREEN_MASK, 32'h0000_FF00);
      write_reg(CSR_BLUE_MASK, 32'h0000_00FF);
      write_reg(CSR_KEY_COLOR, 32'h00FF_FFFF);
      @(posedge clock);
      pixel_q.push_back(32'h00FF_FFFF);
      pixel_q.push_back(32'h01FF_FFFF);
      wait_drained();
      write_reg(CSR_ALPHA_ENABLE, 32'd0);
      @(posedge clock);
      pixel_q.push_back(32'h01FF_FFFF);
      wait_drained();
      setting_cnt++;

      // Back-pressure: long result hold-off while the sender keeps offering
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      stall_req_cnt++;
      repeat (60) pixel_q.push_back($urandom);
      wait_drained();

      // Random settings, each with a run of pixels under one idle mix
      for (k = 0; k < NUM_RAND_PHASES; k++) begin
         case ((k / 4) % 4)
            0: begin
               src_idle_pct  = 0;
               snk_stall_pct = 0;
            end
            1: begin
               src_idle_pct  = 64;
               snk_stall_pct = 0;
            end
            2: begin
               src_idle_pct  = 0;
               snk_stall_pct = 64;
            end
            default: begin
               src_idle_pct  = 10;
               snk_stall_pct = 10;
            end
         endcase
         foreach (masks[i]) begin
            if (k == 0)      masks[i] = '1;
            else if (k == 1) masks[i] = '0;
            else             masks[i] = rand_mask();
         end
         write_reg(CSR_PIXEL_MODE, 32'(k % 4));
         write_reg(CSR_RED_MASK, masks[0]);
         write_reg(CSR_GREEN_MASK, masks[1]);
         write_reg(CSR_BLUE_MASK, masks[2]);
         write_reg(CSR_ALPHA_MASK, masks[3]);
         write_reg(CSR_ALPHA_ENABLE, 32'($urandom_range(1)));
         write_reg(CSR_KEY_ENABLE, 32'($urandom_range(3) != 0));
         // Key on the colour of a chosen word so the match can occur
         key_word = $urandom;
         key_px   = decode_pixel(key_word);
         write_reg(CSR_KEY_COLOR, {8'd0, key_px.red, key_px.green, key_px.blue});
         @(posedge clock);
         repeat (ITEMS_PER_PHASE) pixel_q.push_back(rand_pixel(key_word));
         wait_drained();
         setting_cnt++;
      end

      $display("Decoded %0d of %0d pixels under %0d register settings in all modes; %0d keyed.",
               checked_cnt, accepted_cnt, setting_cnt, keyed_cnt);
      $display("Idle mixes none/sender/receiver/both plus a %0d-cycle hold-off; %0d errors.",
               LONG_STALL, err_cnt);
      if (err_cnt == 0 && decoded_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: bitfield_pixel_unpacker_unit.f
rtl/bpu_pkg.sv
rtl/bpu_req_if.sv
rtl/bpu_rsp_if.sv
rtl/bpu_scale_lane.sv
rtl/bitfield_pixel_unpacker_unit.sv
sim/bitfield_pixel_unpacker_unit_tb.sv
